/* sv/lmps_pkg.sv */
// Shared constants, prefix tables and types for the line multi-pattern scanner.
package lmps_pkg;

   // Default chunk size in bytes (a chunk also ends at a newline)
   localparam int LMPS_CHUNK_BYTES = 1023;

   // Byte window: as long as the longest prefix
   localparam int WINDOW = 11;
   localparam int NUM_PREFIXES = 21;

   localparam int LINE_W = 24;
   localparam int TOTAL_W = 32;
   localparam int RSP_DATA_W = 64;

   localparam logic [LINE_W-1:0] LINE_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam logic [7:0] BYTE_NUL = 8'h00;
   localparam logic [7:0] BYTE_NEWLINE = 8'h0A;

   // Input kind codes carried on tuser
   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_EOF = 1'b1;

   // Prefix lengths in bytes
   localparam logic [3:0] PREFIX_LEN [NUM_PREFIXES] = '{
      4'd3, 4'd7, 4'd4, 4'd4, 4'd5, 4'd4, 4'd11, 4'd4, 4'd4, 4'd4, 4'd6,
      4'd4, 4'd5, 4'd6, 4'd5, 4'd5, 4'd3, 4'd8, 4'd8, 4'd8, 4'd8
   };

   // Prefix text, first character first, padded with zeros
   localparam logic [7:0] PREFIX_TEXT [NUM_PREFIXES][WINDOW] = '{
      '{8'h73, 8'h6B, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h73, 8'h6B, 8'h2D, 8'h61, 8'h6E, 8'h74, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h41, 8'h49, 8'h7A, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h73, 8'h6B, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h70, 8'h70, 8'h6C, 8'h78, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h68, 8'h70, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h69, 8'h74, 8'h68, 8'h75, 8'h62, 8'h5F, 8'h70, 8'h61, 8'h74, 8'h5F},
      '{8'h67, 8'h68, 8'h6F, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h68, 8'h73, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h68, 8'h75, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h6C, 8'h70, 8'h61, 8'h74, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h41, 8'h4B, 8'h49, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h79, 8'h61, 8'h32, 8'h39, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h61, 8'h7A, 8'h75, 8'h72, 8'h65, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h78, 8'h6F, 8'h78, 8'h62, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h78, 8'h6F, 8'h78, 8'h70, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h53, 8'h47, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h73, 8'h6B, 8'h5F, 8'h6C, 8'h69, 8'h76, 8'h65, 8'h5F, 8'h00, 8'h00, 8'h00},
      '{8'h70, 8'h6B, 8'h5F, 8'h6C, 8'h69, 8'h76, 8'h65, 8'h5F, 8'h00, 8'h00, 8'h00},
      '{8'h73, 8'h6B, 8'h5F, 8'h74, 8'h65, 8'h73, 8'h74, 8'h5F, 8'h00, 8'h00, 8'h00},
      '{8'h70, 8'h6B, 8'h5F, 8'h74, 8'h65, 8'h73, 8'h74, 8'h5F, 8'h00, 8'h00, 8'h00}
   };

   // Window control from the chunk logic to the cell row
   typedef struct packed {
      logic shift;
      logic clear;
   } lmps_win_ctrl_type;

   // True when window position pos (0 = newest) takes part in prefix p
   function automatic logic pattern_care(input int p, input int pos);
      pattern_care = (pos < int'(PREFIX_LEN[p]));
   endfunction

   // Byte that prefix p expects at window position pos (0 = newest)
   function automatic logic [7:0] pattern_byte(input int p, input int pos);
      logic [7:0] result;
      result = 8'h00;
      if (pos < int'(PREFIX_LEN[p])) begin
         result = PREFIX_TEXT[p][int'(PREFIX_LEN[p]) - 1 - pos];
      end
      return result;
   endfunction

endpackage

/* sv/lmps_cell.sv */
// One window cell: holds one byte and compares the byte it is about to take.
module lmps_cell #(
   parameter int POS = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lmps_pkg::lmps_win_ctrl_type ctrl,
   input  logic [7:0]                  shift_byte,
   output logic [7:0]                  held_byte,
   output logic [lmps_pkg::NUM_PREFIXES-1:0] cmp_ok
);
   import lmps_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Per-prefix compare of the incoming byte at this position
   always_comb begin
      for (int p = 0; p < NUM_PREFIXES; p++) begin
         cmp_ok[p] = !pattern_care(p, POS) || (shift_byte == pattern_byte(p, POS));
      end
   end

   // Clear at chunk start, otherwise take the neighbor's byte on shift
   always_comb begin
      byte_in = byte_ff;
      if (ctrl.clear) begin
         byte_in = BYTE_NUL;
      end else if (ctrl.shift) begin
         byte_in = shift_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= BYTE_NUL;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign held_byte = byte_ff;

endmodule

/* sv/lmps_window.sv */
// Row of window cells and the prefix hit reduction over them.
module lmps_window (
   input  logic                        clock,
   input  logic                        reset,
   input  lmps_pkg::lmps_win_ctrl_type ctrl,
   input  logic [7:0]                  new_byte,
   output logic                        hit
);
   import lmps_pkg::*;

   logic [7:0]              shift_bytes [WINDOW];
   logic [7:0]              held_bytes [WINDOW-1];
   logic [NUM_PREFIXES-1:0] cmp_ok [WINDOW];
   logic [NUM_PREFIXES-1:0] prefix_hit;

   // Newest byte enters cell zero; each cell feeds the next
   assign shift_bytes[0] = new_byte;

   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign shift_bytes[k] = held_bytes[k-1];
      end
      if (k < WINDOW - 1) begin : g_mid
         lmps_cell #(.POS(k)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .shift_byte (shift_bytes[k]),
            .held_byte  (held_bytes[k]),
            .cmp_ok     (cmp_ok[k])
         );
      end else begin : g_last
         lmps_cell #(.POS(k)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .shift_byte (shift_bytes[k]),
            .held_byte  (),
            .cmp_ok     (cmp_ok[k])
         );
      end
   end

   // A prefix hits when every cell agrees on it
   always_comb begin
      prefix_hit = '1;
      for (int k = 0; k < WINDOW; k++) begin
         prefix_hit = prefix_hit & cmp_ok[k];
      end
   end

   assign hit = |prefix_hit;

endmodule

/* sv/line_multi_pattern_scanner.sv */
// Top level: chunk tracking, counters and result register of the prefix scanner.
//
// Takes one item per clock: a text byte (tuser = 0) or an end-of-file mark
// (tuser = 1). Text is cut into chunks that end after a newline or after
// CHUNK_BYTES bytes; a chunk that contains one of the fixed token prefixes
// before its first NUL byte is flagged. Each chunk end gives one result item
// in the cycle after the byte that closed it: the chunk's line number in the
// current file, the match flag and the saturating total of matched chunks.
// An end-of-file mark flushes a partial chunk and restarts line numbering;
// on an empty chunk it gives no result. The prefix compare runs over an
// 11-cell byte window in the same cycle the byte arrives, so the block
// sustains one item per cycle; req_tready drops only while the result
// register holds an item that the downstream side has not taken.
module line_multi_pattern_scanner #(
   parameter int CHUNK_BYTES = lmps_pkg::LMPS_CHUNK_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] text_byte
   input  logic [0:0]                        req_tuser,  // [0] kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [23:0] line_number, [24] matched, [56:25] leak_total, [63:57] zero
   output logic [lmps_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import lmps_pkg::*;

   localparam int LEN_W = $clog2(CHUNK_BYTES + 1);
   localparam logic [LEN_W-1:0] LAST_LEN = LEN_W'(CHUNK_BYTES - 1);

   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic               matched_ff, matched_in;
   logic               nul_ff, nul_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              is_eof;
   logic [7:0]        text_byte;
   logic              nul_now;
   logic              chunk_hit;
   logic              chunk_end;
   logic              emit;
   logic              emit_matched;
   logic [TOTAL_W-1:0] emit_total;
   lmps_win_ctrl_type win_ctrl;
   logic              win_hit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign is_eof     = (req_tuser[0] == KIND_EOF);
   assign text_byte  = req_tdata;

   // Byte classification for the current item
   assign nul_now   = nul_ff || (text_byte == BYTE_NUL);
   assign chunk_hit = matched_ff || (!nul_now && win_hit);
   assign chunk_end = (text_byte == BYTE_NEWLINE) || (len_ff == LAST_LEN);

   // Result emission and the matched flag that goes with it
   always_comb begin
      emit = 1'b0;
      emit_matched = matched_ff;
      if (req_accept) begin
         if (is_eof) begin
            emit = (len_ff != '0);
         end else begin
            emit = chunk_end;
            emit_matched = chunk_hit;
         end
      end
   end

   assign emit_total = (emit_matched && total_ff != TOTAL_MAX) ? total_ff + 1'b1 : total_ff;

   // Window control: shift compared bytes, clear at every chunk boundary
   always_comb begin
      win_ctrl.shift = req_accept && !is_eof && !nul_now;
      win_ctrl.clear = req_accept && (is_eof || chunk_end);
   end

   lmps_window u_window (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (win_ctrl),
      .new_byte (text_byte),
      .hit      (win_hit)
   );

   // Chunk state and counters
   always_comb begin
      len_in     = len_ff;
      line_in    = line_ff;
      matched_in = matched_ff;
      nul_in     = nul_ff;
      total_in   = total_ff;
      if (emit) begin
         total_in = emit_total;
      end
      if (req_accept) begin
         if (is_eof) begin
            len_in     = '0;
            line_in    = LINE_W'(1);
            matched_in = 1'b0;
            nul_in     = 1'b0;
         end else if (chunk_end) begin
            len_in     = '0;
            line_in    = (line_ff != LINE_MAX) ? line_ff + 1'b1 : line_ff;
            matched_in = 1'b0;
            nul_in     = 1'b0;
         end else begin
            len_in     = len_ff + 1'b1;
            matched_in = chunk_hit;
            nul_in     = nul_now;
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W - LINE_W - 1 - TOTAL_W){1'b0}},
                         emit_total, emit_matched, line_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         line_ff      <= LINE_W'(1);
         matched_ff   <= 1'b0;
         nul_ff       <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         line_ff      <= line_in;
         matched_ff   <= matched_in;
         nul_ff       <= nul_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Chunk length never reaches the chunk size: the last byte closes it
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff < LEN_W'(CHUNK_BYTES))
      else $error("chunk length overran chunk size");

   // Leak total never goes down
   a_total_monotone: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> total_ff >= $past(total_ff))
      else $error("leak total decreased");

   // A new result only follows an accepted item
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept))
      else $error("result appeared without an accepted item");

   // Line numbers start at one
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter is zero");

endmodule
